[hw/rtl/llg_pkg.sv]
// Shared types, constants and arithmetic helpers for the LLG Heun spin step block.
// Used by llg_heun_spin_step_top; depends on nothing else.
package llg_pkg;

	// Depth of the per-atom start spin / first slope store.
	localparam int ATOMS = 4096;

	// Register indexes on the APB port (byte address 4*index).
	typedef enum logic {
		REG_STEP_SIZE  = 1'b0,
		REG_RELAX_ONLY = 1'b1
	} reg_idx_t;

	// Request kinds carried in tuser.
	typedef enum logic {
		REQ_PREDICT = 1'b0,
		REQ_CORRECT = 1'b1
	} req_t;

	typedef logic signed [47:0] s48_t;
	typedef logic signed [32:0] s33_t;
	typedef logic signed [49:0] s50_t;
	typedef logic signed [57:0] pplo_t;
	typedef logic signed [56:0] pphi_t;
	typedef logic signed [80:0] prod_t;

	// One entry of the per-atom store.
	typedef struct packed {
		logic signed [47:0] kz;
		logic signed [47:0] ky;
		logic signed [47:0] kx;
		logic signed [31:0] sz;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
	} ment_t;

	// Sideband that travels along the Newton iterations.
	typedef struct packed {
		logic [11:0]      idx;
		logic [2:0][28:0] nm;
		logic [2:0]       neg;
		logic [29:0]      x;
		logic             kf;
	} nsb_t;

	// One result beat.
	typedef struct packed {
		logic signed [31:0] sz;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
		logic [11:0]        idx;
	} res_t;

	// 3.0 in Q2.30 for the Newton step.
	localparam logic [32:0] THREE_Q30 = 33'h0C0000000;

	// Saturate a 52-bit signed value to signed 48 bits.
	function automatic s48_t sat48(input logic signed [51:0] x);
		s48_t r;
		if (!x[51] && (|x[50:47])) begin
			r = {1'b0, {47{1'b1}}};
		end else if (x[51] && !(&x[50:47])) begin
			r = {1'b1, {47{1'b0}}};
		end else begin
			r = x[47:0];
		end
		return r;
	endfunction

	// Cross product term: sat48(floor(a/2^16) - floor(b/2^16)).
	function automatic s48_t cross_term(input logic signed [63:0] a, input logic signed [63:0] b);
		logic signed [51:0] da;
		logic signed [51:0] db;
		da = {{4{a[63]}}, a[63:16]};
		db = {{4{b[63]}}, b[63:16]};
		return sat48(da - db);
	endfunction

	function automatic s48_t sub50_sat(input s50_t a, input s50_t b);
		logic signed [51:0] r;
		r = {{2{a[49]}}, a} - {{2{b[49]}}, b};
		return sat48(r);
	endfunction

	function automatic s48_t add50_sat(input s50_t a, input s50_t b);
		logic signed [51:0] r;
		r = {{2{a[49]}}, a} + {{2{b[49]}}, b};
		return sat48(r);
	endfunction

	function automatic s48_t add48_sat(input s48_t a, input s48_t b);
		logic signed [51:0] r;
		r = {{4{a[47]}}, a} + {{4{b[47]}}, b};
		return sat48(r);
	endfunction

	// Low partial product: unsigned low 24 bits of c times a.
	function automatic pplo_t pp_lo(input s48_t c, input s33_t a);
		pplo_t r;
		r = $signed({1'b0, c[23:0]}) * a;
		return r;
	endfunction

	// High partial product: signed high 24 bits of c times a.
	function automatic pphi_t pp_hi(input s48_t c, input s33_t a);
		pphi_t r;
		r = $signed(c[47:24]) * a;
		return r;
	endfunction

	// Join the partial products into the full c*a.
	function automatic prod_t pp_join(input pphi_t hi, input pplo_t lo);
		logic [80:0] r;
		r = ({{24{hi[56]}}, hi} << 24) + {{23{lo[57]}}, lo};
		return $signed(r);
	endfunction

	// Inverse square root seed, Q2.30, by the top three bits of the sum of squares.
	function automatic logic [31:0] isqrt_seed(input logic [2:0] sel);
		logic [31:0] r;
		case (sel)
			3'd3:    r = 32'd1623345016;
			3'd4:    r = 32'd1431655765;
			3'd5:    r = 32'd1294981365;
			3'd6:    r = 32'd1191209598;
			3'd7:    r = 32'd1108955787;
			default: r = 32'd1920767767;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/llg_heun_spin_step_top.sv]
// LLG Heun spin step: slope, per-atom store, Euler/Heun update and normalization pipeline.
// Depends on llg_pkg.
//
// Usage:
// - Input beats arrive on s_tvalid/s_tready/s_tdata; s_tuser[0] selects predictor (0) or
//   corrector (1). A predictor stores the start spin and slope by atom and returns the
//   normalized Euler spin; a corrector reads them back and returns the normalized Heun spin.
// - Results leave on m_tvalid/m_tready/m_tdata, one beat per input beat, in input order.
// - step_size and relax_only sit on the APB port; write them only while the block is idle.
// - Throughput: one beat per cycle while the pipeline is not held by a full output buffer.
//   Results pass through 32 register stages (cross products, two rounds of 48x33
//   multiplies split into 24-bit partials, the store access, the dt multiply, leading-one
//   search, sum of squares, four Newton steps of three multiplies each, final scaling).
// - The store is a single-port memory of ATOMS entries, written by predictors and read by
//   correctors at the same stage, so a corrector right behind its predictor sees the new
//   entry. Its contents are undefined after reset until written.
// - Reset clears all valid bits, the output buffer occupancy and both registers.
// - A two-beat output buffer takes results; when it is full and m_tready is low the whole
//   pipeline holds and s_tready drops. A single waiting result does not stop input.
module llg_heun_spin_step_top (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [11:0] atom_index, [43:12] spin_x, [75:44] spin_y, [107:76] spin_z,
	// [139:108] field_x, [171:140] field_y, [203:172] field_z,
	// [234:204] gyro_coeff, [265:235] damp_coeff, [271:266] zero
	input  logic [271:0] s_tdata,
	// [0] req_type
	input  logic [0:0]   s_tuser,
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [11:0] out_atom_index, [43:12] new_spin_x, [75:44] new_spin_y,
	// [107:76] new_spin_z, [111:108] zero
	output logic [111:0] m_tdata,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// ---------------------------------------------------------------- config
	logic [31:0] step_size_q;
	logic        relax_only_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q  <= '0;
			relax_only_q <= 1'b0;
		end else if (cfg_wr) begin
			case (llg_pkg::reg_idx_t'(paddr[2]))
				llg_pkg::REG_STEP_SIZE:  step_size_q  <= pwdata;
				llg_pkg::REG_RELAX_ONLY: relax_only_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (llg_pkg::reg_idx_t'(paddr[2]))
			llg_pkg::REG_STEP_SIZE:  prdata = step_size_q;
			llg_pkg::REG_RELAX_ONLY: prdata = {31'd0, relax_only_q};
			default:                 prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	logic [1:0] ob_cnt_q;
	logic       adv;

	assign adv      = (ob_cnt_q != 2'd2) || m_tready;
	assign s_tready = adv;

	// ---------------------------------------------------------------- input fields
	logic signed [31:0] in_sp [3];
	logic signed [31:0] in_hf [3];

	assign in_sp[0] = s_tdata[43:12];
	assign in_sp[1] = s_tdata[75:44];
	assign in_sp[2] = s_tdata[107:76];
	assign in_hf[0] = s_tdata[139:108];
	assign in_hf[1] = s_tdata[171:140];
	assign in_hf[2] = s_tdata[203:172];

	// ---------------------------------------------------------------- stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s32;

	logic        req_s1, req_s2, req_s3, req_s4, req_s5, req_s6, req_s7, req_s8, req_s9;
	logic        req_s10, req_s11, req_s12;
	logic [11:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8, idx_s9;
	logic [11:0] idx_s10, idx_s11, idx_s12, idx_s13, idx_s14, idx_s15, idx_s16, idx_s17;
	logic [11:0] idx_s18, idx_s19, idx_s32;

	logic signed [31:0] sp_s1 [3];
	logic signed [31:0] sp_s2 [3];
	logic signed [31:0] sp_s3 [3];
	logic signed [31:0] sp_s4 [3];
	logic signed [31:0] sp_s5 [3];
	logic signed [31:0] sp_s6 [3];
	logic signed [31:0] sp_s7 [3];
	logic signed [31:0] sp_s8 [3];
	logic signed [31:0] sp_s9 [3];
	logic signed [31:0] sp_s10 [3];
	logic signed [31:0] hf_s1 [3];

	logic [30:0] gy_s1, gy_s2, gy_s3;
	logic [30:0] dp_s1, dp_s2, dp_s3, dp_s4, dp_s5, dp_s6;

	logic signed [63:0]   xp_s2 [6];
	llg_pkg::s48_t        c_s3 [3];
	llg_pkg::pplo_t       dlo_s4 [6];
	llg_pkg::pphi_t       dhi_s4 [6];
	llg_pkg::pplo_t       plo_s4 [3];
	llg_pkg::pphi_t       phi_s4 [3];
	llg_pkg::s50_t        md_s5 [6];
	llg_pkg::s50_t        mp_s5 [3];
	llg_pkg::s48_t        d_s6 [3];
	llg_pkg::s50_t        mp_s6 [3];
	llg_pkg::pplo_t       elo_s7 [3];
	llg_pkg::pphi_t       ehi_s7 [3];
	llg_pkg::s50_t        mp_s7 [3];
	llg_pkg::s50_t        dd_s8 [3];
	llg_pkg::s50_t        mp_s8 [3];
	llg_pkg::s48_t        k_s9 [3];
	llg_pkg::s48_t        k_s10 [3];
	llg_pkg::ment_t       rd_s10;
	llg_pkg::s48_t        ks_s11 [3];
	logic signed [31:0]   base_s11 [3];
	llg_pkg::pplo_t       tlo_s12 [3];
	llg_pkg::pphi_t       thi_s12 [3];
	logic signed [31:0]   base_s12 [3];
	llg_pkg::s48_t        tm_s13 [3];
	logic signed [31:0]   base_s13 [3];
	logic signed [49:0]   vv_s14 [3];
	logic [49:0]          mag_s15 [3];
	logic [2:0]           neg_s15, neg_s16, neg_s17, neg_s18, neg_s19, neg_s32;
	logic [49:0]          mag_s16 [3];
	logic [5:0]           top_s16;
	logic [28:0]          nm_s17 [3];
	logic [28:0]          nm_s18 [3];
	logic [28:0]          nm_s19 [3];
	logic [57:0]          sq_s18 [3];
	logic [29:0]          x_s19;
	logic [31:0]          y_s19;
	logic                 kf_s19, kf_s32;
	logic [60:0]          op_s32 [3];

	llg_pkg::ment_t mem [llg_pkg::ATOMS];

	// ---------------------------------------------------------------- combinational helpers
	llg_pkg::s33_t sa [3];
	llg_pkg::s33_t gya;
	llg_pkg::s33_t dpa;
	llg_pkg::s33_t dta;
	llg_pkg::prod_t pd [6];
	llg_pkg::prod_t pp [3];
	llg_pkg::prod_t pe [3];
	llg_pkg::prod_t pt [3];
	llg_pkg::s48_t  k1 [3];
	logic signed [31:0] s0 [3];
	logic [49:0] orv;
	logic [5:0]  top_c;
	logic [49:0] shv [3];
	logic [59:0] nsum;
	logic [59:0] nsc;
	logic        kf_c;

	assign gya = {2'b00, gy_s3};
	assign dpa = {2'b00, dp_s6};
	assign dta = {1'b0, step_size_q};

	assign k1[0] = rd_s10.kx;
	assign k1[1] = rd_s10.ky;
	assign k1[2] = rd_s10.kz;
	assign s0[0] = rd_s10.sx;
	assign s0[1] = rd_s10.sy;
	assign s0[2] = rd_s10.sz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sa[i] = {sp_s3[i][31], sp_s3[i]};
			pp[i] = llg_pkg::pp_join(phi_s4[i], plo_s4[i]);
			pe[i] = llg_pkg::pp_join(ehi_s7[i], elo_s7[i]);
			pt[i] = llg_pkg::pp_join(thi_s12[i], tlo_s12[i]);
		end
		for (int i = 0; i < 6; i++) begin
			pd[i] = llg_pkg::pp_join(dhi_s4[i], dlo_s4[i]);
		end
	end

	// Leading one of the largest magnitude
	always_comb begin
		orv   = mag_s15[0] | mag_s15[1] | mag_s15[2];
		top_c = '0;
		for (int i = 0; i < 50; i++) begin
			if (orv[i]) begin
				top_c = 6'(i);
			end
		end
	end

	// Bring the largest magnitude into [2^28, 2^29)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (top_s16 > 6'd28) begin
				shv[i] = mag_s16[i] >> (top_s16 - 6'd28);
			end else begin
				shv[i] = mag_s16[i] << (6'd28 - top_s16);
			end
		end
	end

	// Sum of squares, scaled up when small
	always_comb begin
		nsum = {2'b00, sq_s18[0]} + {2'b00, sq_s18[1]} + {2'b00, sq_s18[2]};
		kf_c = (nsum[59:58] == 2'b00);
		nsc  = kf_c ? (nsum << 2) : nsum;
	end

	// ---------------------------------------------------------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0; v_s5  <= 1'b0;
			v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;  v_s3  <= v_s2;  v_s4  <= v_s3;  v_s5  <= v_s4;
			v_s6  <= v_s5;  v_s7  <= v_s6;  v_s8  <= v_s7;  v_s9  <= v_s8;
			v_s10 <= v_s9;  v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12;
			v_s14 <= v_s13; v_s15 <= v_s14; v_s16 <= v_s15; v_s17 <= v_s16;
			v_s18 <= v_s17; v_s19 <= v_s18;
		end
	end

	// ---------------------------------------------------------------- slope and update payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: capture beat
			req_s1 <= s_tuser[0];
			idx_s1 <= s_tdata[11:0];
			sp_s1  <= in_sp;
			hf_s1  <= in_hf;
			gy_s1  <= s_tdata[234:204];
			dp_s1  <= s_tdata[265:235];

			// s2: S x H products
			req_s2   <= req_s1; idx_s2 <= idx_s1; sp_s2 <= sp_s1;
			gy_s2    <= gy_s1;  dp_s2  <= dp_s1;
			xp_s2[0] <= sp_s1[1] * hf_s1[2];
			xp_s2[1] <= sp_s1[2] * hf_s1[1];
			xp_s2[2] <= sp_s1[2] * hf_s1[0];
			xp_s2[3] <= sp_s1[0] * hf_s1[2];
			xp_s2[4] <= sp_s1[0] * hf_s1[1];
			xp_s2[5] <= sp_s1[1] * hf_s1[0];

			// s3: saturated cross product
			req_s3 <= req_s2; idx_s3 <= idx_s2; sp_s3 <= sp_s2;
			gy_s3  <= gy_s2;  dp_s3  <= dp_s2;
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= llg_pkg::cross_term(xp_s2[2*i], xp_s2[2*i+1]);
			end

			// s4: partial products for S x (S x H) and precession
			req_s4 <= req_s3; idx_s4 <= idx_s3; sp_s4 <= sp_s3; dp_s4 <= dp_s3;
			dlo_s4[0] <= llg_pkg::pp_lo(c_s3[2], sa[1]);
			dhi_s4[0] <= llg_pkg::pp_hi(c_s3[2], sa[1]);
			dlo_s4[1] <= llg_pkg::pp_lo(c_s3[1], sa[2]);
			dhi_s4[1] <= llg_pkg::pp_hi(c_s3[1], sa[2]);
			dlo_s4[2] <= llg_pkg::pp_lo(c_s3[0], sa[2]);
			dhi_s4[2] <= llg_pkg::pp_hi(c_s3[0], sa[2]);
			dlo_s4[3] <= llg_pkg::pp_lo(c_s3[2], sa[0]);
			dhi_s4[3] <= llg_pkg::pp_hi(c_s3[2], sa[0]);
			dlo_s4[4] <= llg_pkg::pp_lo(c_s3[1], sa[0]);
			dhi_s4[4] <= llg_pkg::pp_hi(c_s3[1], sa[0]);
			dlo_s4[5] <= llg_pkg::pp_lo(c_s3[0], sa[1]);
			dhi_s4[5] <= llg_pkg::pp_hi(c_s3[0], sa[1]);
			for (int i = 0; i < 3; i++) begin
				plo_s4[i] <= llg_pkg::pp_lo(c_s3[i], gya);
				phi_s4[i] <= llg_pkg::pp_hi(c_s3[i], gya);
			end

			// s5: join partials, floor by 2^30; drop precession in relax mode
			req_s5 <= req_s4; idx_s5 <= idx_s4; sp_s5 <= sp_s4; dp_s5 <= dp_s4;
			for (int i = 0; i < 6; i++) begin
				md_s5[i] <= pd[i][79:30];
			end
			for (int i = 0; i < 3; i++) begin
				mp_s5[i] <= relax_only_q ? '0 : pp[i][79:30];
			end

			// s6: damping vector
			req_s6 <= req_s5; idx_s6 <= idx_s5; sp_s6 <= sp_s5; dp_s6 <= dp_s5;
			mp_s6  <= mp_s5;
			for (int i = 0; i < 3; i++) begin
				d_s6[i] <= llg_pkg::sub50_sat(md_s5[2*i], md_s5[2*i+1]);
			end

			// s7: partials of damping term
			req_s7 <= req_s6; idx_s7 <= idx_s6; sp_s7 <= sp_s6; mp_s7 <= mp_s6;
			for (int i = 0; i < 3; i++) begin
				elo_s7[i] <= llg_pkg::pp_lo(d_s6[i], dpa);
				ehi_s7[i] <= llg_pkg::pp_hi(d_s6[i], dpa);
			end

			// s8: join damping term
			req_s8 <= req_s7; idx_s8 <= idx_s7; sp_s8 <= sp_s7; mp_s8 <= mp_s7;
			for (int i = 0; i < 3; i++) begin
				dd_s8[i] <= pe[i][79:30];
			end

			// s9: slope
			req_s9 <= req_s8; idx_s9 <= idx_s8; sp_s9 <= sp_s8;
			for (int i = 0; i < 3; i++) begin
				k_s9[i] <= llg_pkg::add50_sat(mp_s8[i], dd_s8[i]);
			end

			// s10: store access happens alongside
			req_s10 <= req_s9; idx_s10 <= idx_s9; sp_s10 <= sp_s9; k_s10 <= k_s9;

			// s11: pick Euler or Heun slope and base spin
			req_s11 <= req_s10; idx_s11 <= idx_s10;
			for (int i = 0; i < 3; i++) begin
				if (req_s10 == llg_pkg::REQ_CORRECT) begin
					ks_s11[i]   <= llg_pkg::add48_sat(k1[i], k_s10[i]);
					base_s11[i] <= s0[i];
				end else begin
					ks_s11[i]   <= k_s10[i];
					base_s11[i] <= sp_s10[i];
				end
			end

			// s12: partials of slope times dt
			req_s12 <= req_s11; idx_s12 <= idx_s11; base_s12 <= base_s11;
			for (int i = 0; i < 3; i++) begin
				tlo_s12[i] <= llg_pkg::pp_lo(ks_s11[i], dta);
				thi_s12[i] <= llg_pkg::pp_hi(ks_s11[i], dta);
			end

			// s13: floor by 2^32, or 2^33 for the half step
			idx_s13 <= idx_s12; base_s13 <= base_s12;
			for (int i = 0; i < 3; i++) begin
				tm_s13[i] <= (req_s12 == llg_pkg::REQ_CORRECT) ? pt[i][80:33] : pt[i][79:32];
			end

			// s14: updated spin before normalization
			idx_s14 <= idx_s13;
			for (int i = 0; i < 3; i++) begin
				vv_s14[i] <= {{18{base_s13[i][31]}}, base_s13[i]}
					+ {{2{tm_s13[i][47]}}, tm_s13[i]};
			end

			// s15: magnitudes and signs
			idx_s15 <= idx_s14;
			for (int i = 0; i < 3; i++) begin
				mag_s15[i] <= vv_s14[i][49] ? 50'(-vv_s14[i]) : 50'(vv_s14[i]);
				neg_s15[i] <= vv_s14[i][49];
			end

			// s16: leading one position
			idx_s16 <= idx_s15; mag_s16 <= mag_s15; neg_s16 <= neg_s15; top_s16 <= top_c;

			// s17: scaled magnitudes
			idx_s17 <= idx_s16; neg_s17 <= neg_s16;
			for (int i = 0; i < 3; i++) begin
				nm_s17[i] <= shv[i][28:0];
			end

			// s18: squares
			idx_s18 <= idx_s17; neg_s18 <= neg_s17; nm_s18 <= nm_s17;
			for (int i = 0; i < 3; i++) begin
				sq_s18[i] <= nm_s17[i] * nm_s17[i];
			end

			// s19: Newton operand and seed
			idx_s19 <= idx_s18; neg_s19 <= neg_s18; nm_s19 <= nm_s18;
			x_s19   <= nsc[59:30];
			y_s19   <= llg_pkg::isqrt_seed(nsc[59:57]);
			kf_s19  <= kf_c;
		end
	end

	// Per-atom store: predictor writes, corrector reads, both at the slope stage
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s9 && (req_s9 == llg_pkg::REQ_PREDICT)) begin
				mem[idx_s9] <= '{kz: k_s9[2], ky: k_s9[1], kx: k_s9[0],
					sz: sp_s9[2], sy: sp_s9[1], sx: sp_s9[0]};
			end else begin
				rd_s10 <= mem[idx_s9];
			end
		end
	end

	// ---------------------------------------------------------------- Newton iterations
	logic          nt_vin [5];
	logic [31:0]   nt_yin [5];
	llg_pkg::nsb_t nt_sbin [5];

	logic          nt_va_s [4];
	logic          nt_vb_s [4];
	logic          nt_vc_s [4];
	logic [31:0]   nt_ya_s [4];
	logic [32:0]   nt_y2_s [4];
	logic [31:0]   nt_yb_s [4];
	logic [31:0]   nt_f_s [4];
	logic [31:0]   nt_yc_s [4];
	llg_pkg::nsb_t nt_sba_s [4];
	llg_pkg::nsb_t nt_sbb_s [4];
	llg_pkg::nsb_t nt_sbc_s [4];

	assign nt_vin[0]  = v_s19;
	assign nt_yin[0]  = y_s19;
	assign nt_sbin[0] = '{idx: idx_s19, nm: {nm_s19[2], nm_s19[1], nm_s19[0]},
		neg: neg_s19, x: x_s19, kf: kf_s19};

	for (genvar j = 0; j < 4; j++) begin : g_newton
		logic [63:0] sq_y;
		logic [62:0] xy2;
		logic [32:0] t_c;
		logic [63:0] yf;

		assign sq_y = nt_yin[j] * nt_yin[j];
		assign xy2  = nt_sba_s[j].x * nt_y2_s[j];
		assign t_c  = xy2[62:30];
		assign yf   = nt_yb_s[j] * nt_f_s[j];

		// Advance valid bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nt_va_s[j] <= 1'b0;
				nt_vb_s[j] <= 1'b0;
				nt_vc_s[j] <= 1'b0;
			end else if (adv) begin
				nt_va_s[j] <= nt_vin[j];
				nt_vb_s[j] <= nt_va_s[j];
				nt_vc_s[j] <= nt_vb_s[j];
			end
		end

		// y2 = y*y, f = 3 - x*y2 (floored at zero), y = y*f
		always_ff @(posedge clk) begin
			if (adv) begin
				nt_ya_s[j]  <= nt_yin[j];
				nt_y2_s[j]  <= sq_y[62:30];
				nt_sba_s[j] <= nt_sbin[j];
				nt_yb_s[j]  <= nt_ya_s[j];
				nt_f_s[j]   <= (t_c >= llg_pkg::THREE_Q30) ? 32'd0
					: 32'(llg_pkg::THREE_Q30 - t_c);
				nt_sbb_s[j] <= nt_sba_s[j];
				nt_yc_s[j]  <= yf[62:31];
				nt_sbc_s[j] <= nt_sbb_s[j];
			end
		end

		assign nt_vin[j+1]  = nt_vc_s[j];
		assign nt_yin[j+1]  = nt_yc_s[j];
		assign nt_sbin[j+1] = nt_sbc_s[j];
	end

	// ---------------------------------------------------------------- output scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s32 <= 1'b0;
		end else if (adv) begin
			v_s32 <= nt_vin[4];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s32 <= nt_sbin[4].idx;
			neg_s32 <= nt_sbin[4].neg;
			kf_s32  <= nt_sbin[4].kf;
			for (int i = 0; i < 3; i++) begin
				op_s32[i] <= nt_sbin[4].nm[i] * nt_yin[4];
			end
		end
	end

	// Round half up, cap, restore sign
	llg_pkg::res_t res_c;
	logic [61:0]   rsum [3];
	logic [32:0]   rmag [3];
	logic [31:0]   rcap [3];
	logic signed [31:0] rout [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (kf_s32) begin
				rsum[i] = {1'b0, op_s32[i]} + 62'h10000000;
				rmag[i] = rsum[i][61:29];
			end else begin
				rsum[i] = {1'b0, op_s32[i]} + 62'h20000000;
				rmag[i] = {1'b0, rsum[i][61:30]};
			end
			rcap[i] = (rmag[i] > 33'h07FFFFFFF) ? 32'h7FFFFFFF : rmag[i][31:0];
			rout[i] = neg_s32[i] ? -rcap[i] : rcap[i];
		end
		res_c = '{sz: rout[2], sy: rout[1], sx: rout[0], idx: idx_s32};
	end

	// ---------------------------------------------------------------- output buffer
	llg_pkg::res_t ob0_q;
	llg_pkg::res_t ob1_q;
	logic          push;
	logic          pop;

	assign push = adv && v_s32;
	assign pop  = (ob_cnt_q != 2'd0) && m_tready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (push && !pop) begin
			ob_cnt_q <= ob_cnt_q + 2'd1;
		end else if (pop && !push) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	// Shift entries toward the head
	always_ff @(posedge clk) begin
		if (pop) begin
			if (ob_cnt_q == 2'd2) begin
				ob0_q <= ob1_q;
				if (push) begin
					ob1_q <= res_c;
				end
			end else if (push) begin
				ob0_q <= res_c;
			end
		end else if (push) begin
			if (ob_cnt_q == 2'd0) begin
				ob0_q <= res_c;
			end else begin
				ob1_q <= res_c;
			end
		end
	end

	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign m_tdata  = {4'd0, ob0_q};

endmodule

[sim/tb.sv]
// Testbench for llg_heun_spin_step_top: drives predictor/corrector beats and APB writes,
// and checks every result beat against a bit-exact model kept in a scoreboard class.
// Depends on llg_pkg and llg_heun_spin_step_top.
`timescale 1ns / 1ps

module tb;

	localparam int N_RANDOM   = 1450;
	localparam int TAIL_ITEMS = 150;
	localparam int DRAIN_WAIT = 48;
	localparam int STALL_LIMIT = 6000;
	localparam longint MAX48 = 64'sh00007FFFFFFFFFFF;
	localparam longint MIN48 = -64'sh0000800000000000;

	// Heun step model: per-atom start spin and first slope, expected result queue
	class spin_predictor_board;
		int unsigned   step_dt;
		bit            relax;
		longint        s0x[llg_pkg::ATOMS], s0y[llg_pkg::ATOMS], s0z[llg_pkg::ATOMS];
		longint        k1x[llg_pkg::ATOMS], k1y[llg_pkg::ATOMS], k1z[llg_pkg::ATOMS];
		llg_pkg::res_t expected_spins[$];
		int            errors;

		function longint sat48(longint x);
			return x > MAX48 ? MAX48 : (x < MIN48 ? MIN48 : x);
		endfunction

		// floor(c*a / 2^sh), exact
		function longint mul_floor(longint c, longint a, int sh);
			logic signed [127:0] p;
			p = 128'(c) * 128'(a);
			p = p >>> sh;
			return longint'(p);
		endfunction

		function void slope(longint s[3], longint h[3], longint g, longint d,
				output longint k[3]);
			longint c[3], dd[3], prec;
			c[0] = sat48((s[1] * h[2] >>> 16) - (s[2] * h[1] >>> 16));
			c[1] = sat48((s[2] * h[0] >>> 16) - (s[0] * h[2] >>> 16));
			c[2] = sat48((s[0] * h[1] >>> 16) - (s[1] * h[0] >>> 16));
			dd[0] = sat48(mul_floor(c[2], s[1], 30) - mul_floor(c[1], s[2], 30));
			dd[1] = sat48(mul_floor(c[0], s[2], 30) - mul_floor(c[2], s[0], 30));
			dd[2] = sat48(mul_floor(c[1], s[0], 30) - mul_floor(c[0], s[1], 30));
			for (int i = 0; i < 3; i++) begin
				prec = relax ? 0 : mul_floor(c[i], g, 30);
				k[i] = sat48(prec + mul_floor(dd[i], d, 30));
			end
		endfunction

		function longint unsigned seed(int sel);
			case (sel)
				3: return 1623345016;
				4: return 1431655765;
				5: return 1294981365;
				6: return 1191209598;
				7: return 1108955787;
				default: return 1920767767;
			endcase
		endfunction

		// Scale to unit length with a seeded four-step Newton inverse square root
		function void unit_vec(longint v[3], output logic [31:0] o[3]);
			longint unsigned mag[3], m, n, x, y, y2, t, f, r;
			int top, kf;
			m = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = v[i] < 0 ? -v[i] : v[i];
				if (mag[i] > m) m = mag[i];
			end
			if (m == 0) begin
				o[0] = 0; o[1] = 0; o[2] = 0;
				return;
			end
			top = 0;
			while (top < 63 && (m >> (top + 1)) != 0) top++;
			for (int i = 0; i < 3; i++)
				mag[i] = top > 28 ? mag[i] >> (top - 28) : mag[i] << (28 - top);
			n = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			kf = 0;
			if (n < (64'd1 << 58)) begin
				n = n << 2;
				kf = 1;
			end
			x = n >> 30;
			y = seed(int'((n >> 57) & 7));
			for (int it = 0; it < 4; it++) begin
				y2 = (y * y) >> 30;
				t = (x * y2) >> 30;
				f = t >= (64'd3 << 30) ? 0 : (64'd3 << 30) - t;
				y = (y * f) >> 31;
			end
			for (int i = 0; i < 3; i++) begin
				r = (mag[i] * y + (64'd1 << (29 - kf))) >> (30 - kf);
				if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
				o[i] = v[i] < 0 ? 32'(-r) : 32'(r);
			end
		endfunction

		// Note an accepted input beat and queue the spin it must produce
		function void note_beat(llg_pkg::req_t rq, logic [271:0] d);
			longint s[3], h[3], k[3], v[3], g, dp;
			logic [31:0] o[3];
			logic [11:0] idx;
			llg_pkg::res_t e;
			idx = d[11:0];
			for (int i = 0; i < 3; i++) begin
				s[i] = longint'($signed(d[12 + 32*i +: 32]));
				h[i] = longint'($signed(d[108 + 32*i +: 32]));
			end
			g  = longint'(d[234:204]);
			dp = longint'(d[265:235]);
			slope(s, h, g, dp, k);
			if (rq == llg_pkg::REQ_PREDICT) begin
				s0x[idx] = s[0]; s0y[idx] = s[1]; s0z[idx] = s[2];
				k1x[idx] = k[0]; k1y[idx] = k[1]; k1z[idx] = k[2];
				for (int i = 0; i < 3; i++)
					v[i] = s[i] + mul_floor(k[i], longint'(step_dt), 32);
			end else begin
				v[0] = s0x[idx] + mul_floor(sat48(k1x[idx] + k[0]), longint'(step_dt), 33);
				v[1] = s0y[idx] + mul_floor(sat48(k1y[idx] + k[1]), longint'(step_dt), 33);
				v[2] = s0z[idx] + mul_floor(sat48(k1z[idx] + k[2]), longint'(step_dt), 33);
			end
			unit_vec(v, o);
			e.idx = idx; e.sx = o[0]; e.sy = o[1]; e.sz = o[2];
			expected_spins.push_back(e);
		endfunction

		// Compare a result beat with the oldest queued spin
		function void check_beat(logic [111:0] d);
			llg_pkg::res_t e;
			if (expected_spins.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", d);
				return;
			end
			e = expected_spins.pop_front();
			if (d[11:0] !== e.idx || d[43:12] !== e.sx || d[75:44] !== e.sy
					|| d[107:76] !== e.sz || d[111:108] !== 4'd0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp idx %0d x %h y %h z %h, got idx %0d x %h y %h z %h",
						e.idx, e.sx, e.sy, e.sz, d[11:0], d[43:12], d[75:44], d[107:76]);
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [271:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [111:0] m_tdata;
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	spin_predictor_board board = new();
	bit   tail_mode = 0;
	bit   hold_request = 0;
	int   idle_cycles = 0;
	bit   written[llg_pkg::ATOMS];
	int   stored_atoms[$];

	llg_heun_spin_step_top DUT (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Check result beats; count cycles with no traffic
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_beat(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold on request, none in the tail
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				m_tready <= 0;
				repeat (300) @(negedge clk);
			end else if (!tail_mode && $urandom_range(0, 9) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
				repeat ($urandom_range(0, 30)) @(negedge clk);
			end
		end
	end

	task automatic reg_write(llg_pkg::reg_idx_t r, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {r, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (r == llg_pkg::REG_STEP_SIZE) board.step_dt = val;
		else board.relax = val[0];
	endtask

	// Present one beat and hold it until accepted
	task automatic send_beat(llg_pkg::req_t rq, logic [11:0] idx, logic [31:0] sp[3],
			logic [31:0] fl[3], logic [30:0] g, logic [30:0] dp);
		logic [271:0] d;
		d = {6'd0, dp, g, fl[2], fl[1], fl[0], sp[2], sp[1], sp[0], idx};
		@(negedge clk);
		s_tvalid <= 1; s_tdata <= d; s_tuser <= rq;
		do @(posedge clk); while (!s_tready);
		board.note_beat(rq, d);
		if (rq == llg_pkg::REQ_PREDICT && !written[idx]) begin
			written[idx] = 1;
			stored_atoms.push_back(idx);
		end
	endtask

	task automatic sender_gap();
		if (!tail_mode && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat ($urandom_range(1, 18) - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 0;
		while (board.expected_spins.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_spin();
		case ($urandom_range(0, 3))
			0: return $urandom;
			default: return 32'($urandom_range(0, 32'h7FFFFFFF)) - 32'h40000000;
		endcase
	endfunction

	function automatic logic [31:0] rand_field();
		logic signed [31:0] f;
		f = $urandom;
		return f >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [30:0] rand_coeff();
		return $urandom_range(0, 7) == 0 ? 31'h40000000 : 31'($urandom_range(0, 32'h40000000));
	endfunction

	task automatic random_item();
		logic [31:0] sp[3], fl[3];
		logic [11:0] idx;
		llg_pkg::req_t rq;
		for (int i = 0; i < 3; i++) begin
			sp[i] = rand_spin();
			fl[i] = rand_field();
		end
		idx = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 31));
		rq = llg_pkg::REQ_PREDICT;
		if (stored_atoms.size() != 0 && $urandom_range(0, 1)) begin
			rq = llg_pkg::REQ_CORRECT;
			idx = stored_atoms[$urandom_range(0, stored_atoms.size() - 1)];
		end
		send_beat(rq, idx, sp, fl, rand_coeff(), rand_coeff());
		// a corrector right behind its own predictor
		if (rq == llg_pkg::REQ_PREDICT && $urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 3; i++) sp[i] = rand_spin();
			send_beat(llg_pkg::REQ_CORRECT, idx, sp, fl, rand_coeff(), rand_coeff());
		end
		sender_gap();
	endtask

	// Main sequence: directed corners, then random phases over several register settings
	initial begin
		logic [31:0] sp[3], fl[3], z3[3], mx[3], mn[3];
		logic [31:0] dts[5];
		bit rlx[5];
		z3 = '{0, 0, 0};
		mx = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		mn = '{32'h80000000, 32'h80000000, 32'h80000000};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		reg_write(llg_pkg::REG_STEP_SIZE, 32'h01000000);
		reg_write(llg_pkg::REG_RELAX_ONLY, 1'b0);
		// zero spin gives a zero vector
		send_beat(llg_pkg::REQ_PREDICT, 12'd0, z3, mx, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd0, z3, mx, 31'h40000000, 31'h40000000);
		// extreme spins and fields, saturating slopes
		send_beat(llg_pkg::REQ_PREDICT, 12'd4095, mn, mx, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_PREDICT, 12'd1, mx, mn, 31'h40000000, 31'h0);
		sp = '{32'h40000000, 0, 0};
		fl = '{0, 32'h7FFFFFFF, 32'h80000000};
		send_beat(llg_pkg::REQ_PREDICT, 12'd2, sp, fl, 31'h0, 31'h40000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd4095, mx, mn, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd1, sp, fl, 31'h20000000, 31'h20000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd2, mn, mn, 31'h0, 31'h0);
		sp = '{32'hC0000000, 32'h00000001, 32'hFFFFFFFF};
		send_beat(llg_pkg::REQ_PREDICT, 12'd3, sp, fl, 31'h40000000, 31'h1);
		send_beat(llg_pkg::REQ_CORRECT, 12'd3, sp, mx, 31'h1, 31'h40000000);
		wait_drained();
		reg_write(llg_pkg::REG_RELAX_ONLY, 1'b1);
		reg_write(llg_pkg::REG_STEP_SIZE, 32'hFFFFFFFF);
		send_beat(llg_pkg::REQ_PREDICT, 12'd5, mx, mn, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd5, mn, mx, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_PREDICT, 12'd6, sp, fl, 31'h40000000, 31'h40000000);
		send_beat(llg_pkg::REQ_CORRECT, 12'd6, sp, fl, 31'h40000000, 31'h40000000);

		dts = '{32'h00400000, 32'hFFFFFFFF, 32'h0, 32'h12345678, 32'h80000000};
		rlx = '{0, 1, 0, 1, 0};
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			reg_write(llg_pkg::REG_STEP_SIZE, dts[ph] == 32'h12345678 ? $urandom : dts[ph]);
			reg_write(llg_pkg::REG_RELAX_ONLY, rlx[ph]);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				if (ph == 1 && n == 40) hold_request = 1;
				if (ph == 2 && n == 100) wait_drained();
				if (ph == 4 && n >= N_RANDOM / 5 - TAIL_ITEMS) tail_mode = 1;
				random_item();
			end
		end

		@(negedge clk);
		s_tvalid <= 0;
		while (board.expected_spins.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (board.errors == 0 && board.expected_spins.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
